@@ hw/rtl/sit_pkg.sv @@
// shared types, widths and helpers for the segment intersection test
package sit_pkg;

  localparam int FIELD_W    = 16;
  localparam int COORD_BITS = 16;
  localparam int TOL_W      = 32;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int CMP_W      = ((CROSS_W > TOL_W) ? CROSS_W : TOL_W) + 1;
  localparam int N_ORIENT   = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;

  typedef enum logic [1:0] {
    ORIENT_COLLINEAR = 2'd0,
    ORIENT_CCW       = 2'd1,
    ORIENT_CW        = 2'd2
  } orient_t;

  // operands of one cross product ux*vy - uy*vx
  typedef struct packed {
    diff_t ux;
    diff_t uy;
    diff_t vx;
    diff_t vy;
  } cross_ops_t;

  typedef struct packed {
    cross_ops_t [N_ORIENT-1:0] ops;
    logic       [N_ORIENT-1:0] box;
  } diff_stage_t;

  typedef struct packed {
    prod_t [N_ORIENT-1:0] pa;
    prod_t [N_ORIENT-1:0] pb;
    logic  [N_ORIENT-1:0] box;
  } prod_stage_t;

  typedef struct packed {
    cross_t [N_ORIENT-1:0] xprod;
    logic   [N_ORIENT-1:0] box;
  } cross_stage_t;

  typedef struct packed {
    orient_t [N_ORIENT-1:0] orient;
    logic    [N_ORIENT-1:0] box;
  } orient_stage_t;

  // low COORD_BITS of the field, sign-extended from the top kept bit
  function automatic coord_t coord_of(input logic [FIELD_W-1:0] raw);
    logic [63:0] wide;
    wide = 64'(raw);
    return coord_t'(wide[COORD_BITS-1:0]);
  endfunction

  // inclusive bounding box test of p against segment e0-e1, one axis
  function automatic logic in_span(input coord_t e0, input coord_t e1, input coord_t p);
    return (p <= e0 || p <= e1) && (p >= e0 || p >= e1);
  endfunction

endpackage

@@ hw/rtl/segment_intersection_test.sv @@
// top level of the segment intersection test pipeline
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in_     | input     | in_valid / in_stall       | a_/b_ start/end x/y, 16b signed
//  out_    | output    | out_valid / out_stall     | out_intersects, 1b
//  cfg_    | input     | cfg_valid / cfg_ready     | cfg_data, collinear tolerance 32b
//
//  one pair per cycle sustained while out_stall is low; the stages are diff,
//  multiply, subtract, classify and combine
//  rst_n is synchronous active low; it clears the stage valid bits and the
//  tolerance register, payload registers are not reset
//  each stage advances when it is empty or the stage after it advances, so bubbles
//  collapse; input transfers fill free stages while a result waits under out_stall
//  cfg_ready is always high; the tolerance is read live by the classify stage
module segment_intersection_test
  import sit_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] in_a_start_x,
  input  logic [FIELD_W-1:0] in_a_start_y,
  input  logic [FIELD_W-1:0] in_a_end_x,
  input  logic [FIELD_W-1:0] in_a_end_y,
  input  logic [FIELD_W-1:0] in_b_start_x,
  input  logic [FIELD_W-1:0] in_b_start_y,
  input  logic [FIELD_W-1:0] in_b_end_x,
  input  logic [FIELD_W-1:0] in_b_end_y,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_intersects,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TOL_W-1:0]   cfg_data
);

  // collinear tolerance register
  logic [TOL_W-1:0] tol_r;

  // stage valid bits and enables
  logic          diff_valid, mul_valid, cross_valid, orient_valid;
  logic          en_diff, en_mul, en_sub, en_orient, en_out;
  diff_stage_t   diff_data;
  cross_stage_t  cross_data;
  orient_stage_t orient_data;

  logic out_valid_r;
  logic out_intersects_r;
  logic hit_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  // backward enable chain: a stage loads when empty or when its contents move on
  assign en_out    = !out_valid_r || !out_stall;
  assign en_orient = !orient_valid || en_out;
  assign en_sub    = !cross_valid || en_orient;
  assign en_mul    = !mul_valid || en_sub;
  assign en_diff   = !diff_valid || en_mul;
  assign in_stall  = !en_diff;

  sit_diff_stage u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_diff),
    .valid_in  (in_valid),
    .a_start_x (in_a_start_x),
    .a_start_y (in_a_start_y),
    .a_end_x   (in_a_end_x),
    .a_end_y   (in_a_end_y),
    .b_start_x (in_b_start_x),
    .b_start_y (in_b_start_y),
    .b_end_x   (in_b_end_x),
    .b_end_y   (in_b_end_y),
    .valid_r   (diff_valid),
    .data_r    (diff_data)
  );

  sit_cross_unit u_cross (
    .clk         (clk),
    .rst_n       (rst_n),
    .en_mul      (en_mul),
    .en_sub      (en_sub),
    .valid_in    (diff_valid),
    .data_in     (diff_data),
    .mul_valid_r (mul_valid),
    .valid_r     (cross_valid),
    .data_r      (cross_data)
  );

  sit_orient_stage u_orient (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en_orient),
    .valid_in (cross_valid),
    .data_in  (cross_data),
    .tol      (tol_r),
    .valid_r  (orient_valid),
    .data_r   (orient_data)
  );

  // proper crossing when both orientation pairs differ, otherwise a collinear
  // point inside the other segment's box counts as touching
  always_comb begin
    hit_nxt = (orient_data.orient[0] != orient_data.orient[1]) &&
              (orient_data.orient[2] != orient_data.orient[3]);
    for (int i = 0; i < N_ORIENT; i++) begin
      if (orient_data.orient[i] == ORIENT_COLLINEAR && orient_data.box[i]) begin
        hit_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= orient_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_intersects_r <= hit_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_intersects = out_intersects_r;

endmodule

@@ hw/rtl/sit_diff_stage.sv @@
// first stage: coordinate differences and bounding box flags
module sit_diff_stage
  import sit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic [FIELD_W-1:0]   a_start_x,
  input  logic [FIELD_W-1:0]   a_start_y,
  input  logic [FIELD_W-1:0]   a_end_x,
  input  logic [FIELD_W-1:0]   a_end_y,
  input  logic [FIELD_W-1:0]   b_start_x,
  input  logic [FIELD_W-1:0]   b_start_y,
  input  logic [FIELD_W-1:0]   b_end_x,
  input  logic [FIELD_W-1:0]   b_end_y,
  output logic                 valid_r,
  output diff_stage_t          data_r
);

  coord_t      asx, asy, aex, aey, bsx, bsy, bex, bey;
  diff_t       a_ux, a_uy, b_ux, b_uy;
  diff_stage_t data_nxt;

  always_comb begin
    asx = coord_of(a_start_x);
    asy = coord_of(a_start_y);
    aex = coord_of(a_end_x);
    aey = coord_of(a_end_y);
    bsx = coord_of(b_start_x);
    bsy = coord_of(b_start_y);
    bex = coord_of(b_end_x);
    bey = coord_of(b_end_y);

    a_ux = DIFF_W'(aex) - DIFF_W'(asx);
    a_uy = DIFF_W'(aey) - DIFF_W'(asy);
    b_ux = DIFF_W'(bex) - DIFF_W'(bsx);
    b_uy = DIFF_W'(bey) - DIFF_W'(bsy);

    // b_start against segment a
    data_nxt.ops[0].ux = a_ux;
    data_nxt.ops[0].uy = a_uy;
    data_nxt.ops[0].vx = DIFF_W'(bsx) - DIFF_W'(asx);
    data_nxt.ops[0].vy = DIFF_W'(bsy) - DIFF_W'(asy);
    // b_end against segment a
    data_nxt.ops[1].ux = a_ux;
    data_nxt.ops[1].uy = a_uy;
    data_nxt.ops[1].vx = DIFF_W'(bex) - DIFF_W'(asx);
    data_nxt.ops[1].vy = DIFF_W'(bey) - DIFF_W'(asy);
    // a_start against segment b
    data_nxt.ops[2].ux = b_ux;
    data_nxt.ops[2].uy = b_uy;
    data_nxt.ops[2].vx = DIFF_W'(asx) - DIFF_W'(bsx);
    data_nxt.ops[2].vy = DIFF_W'(asy) - DIFF_W'(bsy);
    // a_end against segment b
    data_nxt.ops[3].ux = b_ux;
    data_nxt.ops[3].uy = b_uy;
    data_nxt.ops[3].vx = DIFF_W'(aex) - DIFF_W'(bsx);
    data_nxt.ops[3].vy = DIFF_W'(aey) - DIFF_W'(bsy);

    data_nxt.box[0] = in_span(asx, aex, bsx) && in_span(asy, aey, bsy);
    data_nxt.box[1] = in_span(asx, aex, bex) && in_span(asy, aey, bey);
    data_nxt.box[2] = in_span(bsx, bex, asx) && in_span(bsy, bey, asy);
    data_nxt.box[3] = in_span(bsx, bex, aex) && in_span(bsy, bey, aey);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hw/rtl/sit_cross_unit.sv @@
// two stages: partial products, then the cross product subtraction
module sit_cross_unit
  import sit_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en_mul,
  input  logic          en_sub,
  input  logic          valid_in,
  input  diff_stage_t   data_in,
  output logic          mul_valid_r,
  output logic          valid_r,
  output cross_stage_t  data_r
);

  prod_stage_t  mul_r;
  prod_stage_t  mul_nxt;
  cross_stage_t data_nxt;

  always_comb begin
    for (int i = 0; i < N_ORIENT; i++) begin
      mul_nxt.pa[i] = PROD_W'(data_in.ops[i].ux) * PROD_W'(data_in.ops[i].vy);
      mul_nxt.pb[i] = PROD_W'(data_in.ops[i].uy) * PROD_W'(data_in.ops[i].vx);
    end
    mul_nxt.box = data_in.box;
  end

  always_comb begin
    for (int i = 0; i < N_ORIENT; i++) begin
      data_nxt.xprod[i] = CROSS_W'($signed(mul_r.pa[i])) - CROSS_W'($signed(mul_r.pb[i]));
    end
    data_nxt.box = mul_r.box;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      if (en_mul) begin
        mul_valid_r <= valid_in;
      end
      if (en_sub) begin
        valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      mul_r <= mul_nxt;
    end
    if (en_sub) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hw/rtl/sit_orient_stage.sv @@
// orientation classification against the collinear dead band
module sit_orient_stage
  import sit_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_in,
  input  cross_stage_t    data_in,
  input  logic [TOL_W-1:0] tol,
  output logic            valid_r,
  output orient_stage_t   data_r
);

  logic signed [CMP_W-1:0] tol_pos;
  logic signed [CMP_W-1:0] tol_neg;
  logic signed [CMP_W-1:0] cross_ext;
  orient_stage_t           data_nxt;

  always_comb begin
    tol_pos = $signed(CMP_W'(tol));
    tol_neg = -tol_pos;
    cross_ext = '0;
    for (int i = 0; i < N_ORIENT; i++) begin
      cross_ext = CMP_W'($signed(data_in.xprod[i]));
      if (cross_ext < tol_neg) begin
        data_nxt.orient[i] = ORIENT_CW;
      end else if (cross_ext > tol_pos) begin
        data_nxt.orient[i] = ORIENT_CCW;
      end else begin
        data_nxt.orient[i] = ORIENT_COLLINEAR;
      end
    end
    data_nxt.box = data_in.box;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ test/tb.sv @@
// testbench for the segment intersection test pipeline
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  // pipeline depth, the stage count of the top level
  localparam int PIPE_LATENCY = 5;
  // run length cap; the slowest legal run is far below this
  localparam int CYCLE_LIMIT  = 200000;
  // length of the long receiver hold-off, in cycles
  localparam int LONG_HOLD    = 200;

  // one segment pair as it goes on the input channel
  typedef struct packed {
    logic [FIELD_W-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
    logic [FIELD_W-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
  } seg_pair_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] in_a_start_x   = '0;
  logic [FIELD_W-1:0] in_a_start_y   = '0;
  logic [FIELD_W-1:0] in_a_end_x     = '0;
  logic [FIELD_W-1:0] in_a_end_y     = '0;
  logic [FIELD_W-1:0] in_b_start_x   = '0;
  logic [FIELD_W-1:0] in_b_start_y   = '0;
  logic [FIELD_W-1:0] in_b_end_x     = '0;
  logic [FIELD_W-1:0] in_b_end_y     = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               out_intersects;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [TOL_W-1:0]   cfg_data       = '0;

  // predictor copy of the tolerance register
  logic [TOL_W-1:0]   tol_model      = '0;
  // expected intersects flags, oldest first
  logic               touch_q [$];

  int err_count   = 0;
  int cycle_count = 0;

  // sender idling knobs: bursts of 1..12 transfers, idle gaps bounded by gap_max
  int burst_left  = 0;
  int gap_max     = 0;
  // receiver stall knobs
  int stall_pct   = 0;
  int stall_run   = 0;
  logic stall_level = 1'b0;
  logic long_hold_go   = 1'b0;
  logic long_hold_done = 1'b0;
  int hold_count  = 0;

  segment_intersection_test u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_a_start_x   (in_a_start_x),
    .in_a_start_y   (in_a_start_y),
    .in_a_end_x     (in_a_end_x),
    .in_a_end_y     (in_a_end_y),
    .in_b_start_x   (in_b_start_x),
    .in_b_start_y   (in_b_start_y),
    .in_b_end_x     (in_b_end_x),
    .in_b_end_y     (in_b_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_intersects (out_intersects),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // low COORD_BITS of a field, sign-extended
  function automatic longint coord_val(input logic [FIELD_W-1:0] raw);
    logic signed [COORD_BITS-1:0] low;
    low = raw[COORD_BITS-1:0];
    return longint'(low);
  endfunction

  // orientation of r against the directed line p->q, with a collinear dead band
  function automatic orient_t turn_of(input longint px, py, qx, qy, rx, ry, tol);
    longint xprod;
    xprod = (qx - px) * (ry - py) - (qy - py) * (rx - px);
    if (xprod < -tol) return ORIENT_CW;
    if (xprod > tol) return ORIENT_CCW;
    return ORIENT_COLLINEAR;
  endfunction

  // inclusive bounding box of e0-e1 holds p
  function automatic bit in_bbox(input longint e0x, e0y, e1x, e1y, px, py);
    return px <= ((e0x > e1x) ? e0x : e1x) && px >= ((e0x < e1x) ? e0x : e1x)
        && py <= ((e0y > e1y) ? e0y : e1y) && py >= ((e0y < e1y) ? e0y : e1y);
  endfunction

  // expected intersects flag for one pair under the given tolerance
  function automatic logic segments_touch(input seg_pair_t p, input logic [TOL_W-1:0] tol_reg);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, tol;
    orient_t o1, o2, o3, o4;
    ax0 = coord_val(p.a_start_x);
    ay0 = coord_val(p.a_start_y);
    ax1 = coord_val(p.a_end_x);
    ay1 = coord_val(p.a_end_y);
    bx0 = coord_val(p.b_start_x);
    by0 = coord_val(p.b_start_y);
    bx1 = coord_val(p.b_end_x);
    by1 = coord_val(p.b_end_y);
    tol = longint'(tol_reg);
    o1 = turn_of(ax0, ay0, ax1, ay1, bx0, by0, tol);
    o2 = turn_of(ax0, ay0, ax1, ay1, bx1, by1, tol);
    o3 = turn_of(bx0, by0, bx1, by1, ax0, ay0, tol);
    o4 = turn_of(bx0, by0, bx1, by1, ax1, ay1, tol);
    // proper crossing: each segment straddles the other's line
    if (o1 != o2 && o3 != o4) return 1'b1;
    // collinear cases fall back on the bounding box
    if (o1 == ORIENT_COLLINEAR && in_bbox(ax0, ay0, ax1, ay1, bx0, by0)) return 1'b1;
    if (o2 == ORIENT_COLLINEAR && in_bbox(ax0, ay0, ax1, ay1, bx1, by1)) return 1'b1;
    if (o3 == ORIENT_COLLINEAR && in_bbox(bx0, by0, bx1, by1, ax0, ay0)) return 1'b1;
    if (o4 == ORIENT_COLLINEAR && in_bbox(bx0, by0, bx1, by1, ax1, ay1)) return 1'b1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic seg_pair_t mk_pair(input int asx, asy, aex, aey, bsx, bsy, bex, bey);
    seg_pair_t p;
    p.a_start_x = FIELD_W'(asx);
    p.a_start_y = FIELD_W'(asy);
    p.a_end_x   = FIELD_W'(aex);
    p.a_end_y   = FIELD_W'(aey);
    p.b_start_x = FIELD_W'(bsx);
    p.b_start_y = FIELD_W'(bsy);
    p.b_end_x   = FIELD_W'(bex);
    p.b_end_y   = FIELD_W'(bey);
    return p;
  endfunction

  // uniform in -m..m
  function automatic int jitter(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // center for a small cluster, kept clear of the coordinate limits
  function automatic int spot();
    return int'($urandom_range(0, 64000)) - 32000;
  endfunction

  // random pair, biased toward the cases where orientation and box tests matter
  function automatic seg_pair_t rand_pair();
    int kind, cx, cy, dx, dy, k0, k1, k2, k3, s;
    int ext [7];
    seg_pair_t p;
    ext  = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    kind = $urandom_range(0, 99);
    cx   = spot();
    cy   = spot();
    if (kind < 20) begin
      // anything at all, every bit of every field
      p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (kind < 45) begin
      // tight cluster: many touches, near-collinear triples
      p = mk_pair(cx + jitter(4), cy + jitter(4), cx + jitter(4), cy + jitter(4),
                  cx + jitter(4), cy + jitter(4), cx + jitter(4), cy + jitter(4));
    end else if (kind < 60) begin
      // shared endpoint
      p = mk_pair(cx + jitter(40), cy + jitter(40), cx + jitter(40), cy + jitter(40),
                  cx + jitter(40), cy + jitter(40), cx + jitter(40), cy + jitter(40));
      case ($urandom_range(0, 3))
        0: begin p.b_start_x = p.a_start_x; p.b_start_y = p.a_start_y; end
        1: begin p.b_start_x = p.a_end_x;   p.b_start_y = p.a_end_y;   end
        2: begin p.b_end_x   = p.a_start_x; p.b_end_y   = p.a_start_y; end
        default: begin p.b_end_x = p.a_end_x; p.b_end_y = p.a_end_y; end
      endcase
    end else if (kind < 80) begin
      // four points on one line, b_start x sometimes off by one: overlap, touch or gap
      dx = jitter(6);
      dy = jitter(6);
      k0 = jitter(6);
      k1 = jitter(6);
      k2 = jitter(6);
      k3 = jitter(6);
      s  = jitter(1);
      p = mk_pair(cx + k0 * dx, cy + k0 * dy, cx + k1 * dx, cy + k1 * dy,
                  cx + k2 * dx + s, cy + k2 * dy, cx + k3 * dx, cy + k3 * dy);
    end else if (kind < 90) begin
      // one segment collapsed to a point near the other
      p = mk_pair(cx + jitter(8), cy + jitter(8), cx + jitter(8), cy + jitter(8),
                  cx + jitter(8), cy + jitter(8), cx + jitter(8), cy + jitter(8));
      if ($urandom_range(0, 1)) begin
        p.a_end_x = p.a_start_x;
        p.a_end_y = p.a_start_y;
      end else begin
        p.b_end_x = p.b_start_x;
        p.b_end_y = p.b_start_y;
      end
    end else begin
      // coordinate extremes
      p = mk_pair(ext[$urandom_range(0, 6)], ext[$urandom_range(0, 6)],
                  ext[$urandom_range(0, 6)], ext[$urandom_range(0, 6)],
                  ext[$urandom_range(0, 6)], ext[$urandom_range(0, 6)],
                  ext[$urandom_range(0, 6)], ext[$urandom_range(0, 6)]);
    end
    return p;
  endfunction

  // offer one pair until it transfers, with a random gap at burst boundaries
  task automatic send_pair(input seg_pair_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_a_start_x <= p.a_start_x;
    in_a_start_y <= p.a_start_y;
    in_a_end_x   <= p.a_end_x;
    in_a_end_y   <= p.a_end_y;
    in_b_start_x <= p.b_start_x;
    in_b_start_y <= p.b_start_y;
    in_b_end_x   <= p.b_end_x;
    in_b_end_y   <= p.b_end_y;
    // payload holds until the transfer edge
    do @(posedge clk); while (in_stall);
    burst_left--;
    touch_q.push_back(segments_touch(p, tol_model));
  endtask

  // stop offering and wait until every expected result has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (touch_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // tolerance write, only with the pipeline empty
  task automatic set_tolerance(input logic [TOL_W-1:0] tol);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tol;
    do @(posedge clk); while (!cfg_ready);
    tol_model = tol;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall runs, or one long hold-off when asked
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (long_hold_go && !long_hold_done) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= LONG_HOLD) long_hold_done <= 1'b1;
    end else begin
      if (!long_hold_go) begin
        long_hold_done <= 1'b0;
        hold_count = 0;
      end
      if (stall_run == 0) begin
        stall_run   = $urandom_range(1, 6);
        stall_level = ($urandom_range(0, 99) < stall_pct);
      end
      stall_run--;
      out_stall <= stall_level;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each output transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    logic want;
    if (rst_n && out_valid && !out_stall) begin
      if (touch_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual intersects=%0b",
                 $time, out_intersects);
        err_count++;
      end else begin
        want = touch_q.pop_front();
        if (out_intersects !== want) begin
          $display("%0t: intersects mismatch, expected %0b, actual %0b",
                   $time, want, out_intersects);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked geometry at reset tolerance
  task automatic test_directed();
    gap_max   = 0;
    stall_pct = 0;
    send_pair(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));        // plain crossing
    send_pair(mk_pair(0, 0, 10, 0, 0, 5, 10, 5));          // parallel, apart
    send_pair(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));          // collinear overlap
    send_pair(mk_pair(0, 0, 4, 0, 6, 0, 9, 0));            // collinear with a gap
    send_pair(mk_pair(0, 0, 5, 5, 5, 5, 9, 0));            // shared endpoint
    send_pair(mk_pair(0, 0, 10, 0, 5, 0, 5, 7));           // t junction
    send_pair(mk_pair(0, 0, 10, 0, 5, 1, 5, 7));           // near miss
    send_pair(mk_pair(3, 3, 3, 3, 0, 0, 6, 6));            // point on segment
    send_pair(mk_pair(3, 4, 3, 4, 0, 0, 6, 6));            // point off segment
    send_pair(mk_pair(7, -2, 7, -2, 7, -2, 7, -2));        // two equal points
    send_pair(mk_pair(7, -2, 7, -2, 8, -2, 8, -2));        // two distinct points
    send_pair(mk_pair(-5, -5, 5, 5, 4, 4, 20, 20));        // diagonal overlap
    send_pair(mk_pair(0, 0, 3, 3, 3, 3, 8, 8));            // diagonal end to end
    // full coordinate range: largest differences and cross products
    send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk_pair(-32768, -32768, 32767, -32768, 32767, -32768, -32768, -32768));
    send_pair(mk_pair(-32768, 32767, -32768, 32767, 32767, -32768, 32767, 32767));
    send_pair(mk_pair(32767, 0, -32768, 0, 0, 32767, 0, -32768));
    send_pair(mk_pair(-32768, 32767, 32767, 32767, -32768, 32766, 32767, 32766));
    send_pair(mk_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    drain();
  endtask

  // dead band edge: a cross product of ten sits just outside, then just inside the band
  task automatic test_tolerance();
    set_tolerance(32'd9);
    send_pair(mk_pair(0, 0, 10, 0, 5, 1, 5, 10));
    set_tolerance(32'd10);
    send_pair(mk_pair(0, 0, 10, 0, 5, 1, 5, 10));
    // widest band: boxes decide except for the very largest cross products
    set_tolerance(32'hFFFF_FFFF);
    send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk_pair(0, 0, 10, 0, 0, 5, 10, 5));
    send_pair(mk_pair(0, 0, 10, 10, 20, 0, 30, 30));
    drain();
  endtask

  // random pairs over several tolerances and idling mixes
  task automatic test_random();
    set_tolerance('0);
    gap_max   = 6;
    stall_pct = 30;
    repeat (120) send_pair(rand_pair());
    // a stretch with no idling on either side
    gap_max   = 0;
    stall_pct = 0;
    repeat (40) send_pair(rand_pair());
    set_tolerance(TOL_W'($urandom_range(1, 64)));
    gap_max   = 3;
    stall_pct = 50;
    repeat (60) send_pair(rand_pair());
    set_tolerance($urandom);
    gap_max   = 10;
    stall_pct = 20;
    repeat (40) send_pair(rand_pair());
    set_tolerance(32'hFFFF_FFFF);
    gap_max   = 2;
    stall_pct = 70;
    repeat (40) send_pair(rand_pair());
    set_tolerance('0);
  endtask

  // receiver holds off while the sender keeps offering: pipeline fills, input stalls
  task automatic test_backpressure();
    gap_max      = 0;
    stall_pct    = 0;
    long_hold_go = 1'b1;
    repeat (40) send_pair(rand_pair());
    while (!long_hold_done) @(posedge clk);
    long_hold_go = 1'b0;
    drain();
  endtask

  // sender goes quiet until every result is out, then resumes
  task automatic test_pause();
    gap_max   = 4;
    stall_pct = 40;
    repeat (15) send_pair(rand_pair());
    drain();
    repeat (15) send_pair(rand_pair());
    drain();
  endtask

  initial begin
    // synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_tolerance();
    test_random();
    test_backpressure();
    test_pause();

    drain();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sit_pkg.sv
hw/rtl/sit_diff_stage.sv
hw/rtl/sit_cross_unit.sv
hw/rtl/sit_orient_stage.sv
hw/rtl/segment_intersection_test.sv
test/tb.sv
